### sv/assert_macros.svh
// assertion macros shared by the nearest feature selector rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define NFKS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define NFKS_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

### sv/nfks_pkg.sv
// shared types, codes and constants of the nearest feature selector
// no dependencies
`default_nettype none
package nfks_pkg;

	localparam int AIRPORT_CAP_DEF = 200;
	localparam int NAVAID_CAP_DEF  = 100;
	localparam int FIX_DEPTH_DEF   = 512;

	localparam int DIST_W  = 48;
	localparam int ID_W    = 16;
	localparam int ENTRY_W = 17;
	localparam int CAT_W   = 3;
	localparam int LAT_W   = 24;
	localparam int LON_W   = 25;
	localparam int LATWIN_W = 22;
	localparam int LONWIN_W = 24;
	localparam int SCALE_W = 16;
	localparam int MAXC_W  = 10;
	localparam int RPOS_W  = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 25;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [SCALE_W-1:0] LON_SCALE_RST = 16'd32768;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_FETCH = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [CAT_W-1:0] {
		CAT_AIRPORT  = 3'd0,
		CAT_VOR      = 3'd1,
		CAT_NDB      = 3'd2,
		CAT_FIX      = 3'd3,
		CAT_WAYPOINT = 3'd4,
		CAT_OTHER    = 3'd5
	} cat_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OWN_LAT    = 3'd0,
		CFG_OWN_LON    = 3'd1,
		CFG_LAT_WINDOW = 3'd2,
		CFG_LON_WINDOW = 3'd3,
		CFG_LON_SCALE  = 3'd4,
		CFG_MAX_COUNT  = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_FETCH = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		SEL_AIRPORT = 2'd0,
		SEL_NAVAID  = 2'd1,
		SEL_FIX     = 2'd2
	} sel_t;

	typedef struct packed {
		op_t                op;
		sel_t               sel;
		logic [DIST_W-1:0]  range_sq;
		logic [ENTRY_W-1:0] entry;
	} q_item_t;

	typedef struct packed {
		logic signed [LAT_W-1:0] own_lat;
		logic signed [LON_W-1:0] own_lon;
		logic [LATWIN_W-1:0]     lat_window;
		logic [LONWIN_W-1:0]     lon_window;
		logic [SCALE_W-1:0]      lon_scale;
	} geo_cfg_t;

	typedef enum logic [1:0] {
		INS_IDLE  = 2'd0,
		INS_TOP   = 2'd1,
		INS_SHIFT = 2'd2,
		INS_CMP   = 2'd3
	} ins_state_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_LOAD  = 2'd1,
		BK_FETCH = 2'd2
	} bk_state_t;

endpackage
`default_nettype wire

### sv/nfks_front.sv
// front end: box test, distance pipeline and request classification
// depends on nfks_pkg
`default_nettype none
module nfks_front import nfks_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire geo_cfg_t                cfg,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [1:0]              req_type,
	input  wire logic [ID_W-1:0]         feature_id,
	input  wire logic [CAT_W-1:0]        feature_category,
	input  wire logic signed [LAT_W-1:0] feature_lat,
	input  wire logic signed [LON_W-1:0] feature_lon,
	output logic                         push,
	output q_item_t                      push_item,
	input  wire logic                    q_full
);

	logic adv;
	logic signed [LAT_W:0] dlat;
	logic signed [LON_W:0] dlon;
	logic [LAT_W:0] north_full;
	logic [LON_W:0] adlon_full;
	logic in_box, keep;
	op_t op_in;
	sel_t sel_in;
	logic nb_in;
	logic [50:0] sum;

	logic v_s1, v_s2, v_s3, v_s4;
	op_t op_s1, op_s2, op_s3;
	sel_t sel_s1, sel_s2, sel_s3;
	logic [ENTRY_W-1:0] ent_s1, ent_s2, ent_s3;
	logic [LATWIN_W-1:0] north_s1, north_s2;
	logic [LONWIN_W-1:0] adlon_s1;
	logic [39:0] prod_s2;
	logic [43:0] nsq_s3;
	logic [49:0] esq_s3;
	logic [24:0] east;
	q_item_t item_s4;

	assign adv = !(v_s4 && q_full);
	assign in_ready = adv;

	always_comb begin
		dlat = {feature_lat[LAT_W-1], feature_lat} - {cfg.own_lat[LAT_W-1], cfg.own_lat};
		dlon = {feature_lon[LON_W-1], feature_lon} - {cfg.own_lon[LON_W-1], cfg.own_lon};
		north_full = dlat[LAT_W] ? (LAT_W+1)'(-dlat) : (LAT_W+1)'(dlat);
		adlon_full = dlon[LON_W] ? (LON_W+1)'(-dlon) : (LON_W+1)'(dlon);
		in_box = (north_full <= {3'b000, cfg.lat_window}) &&
			(adlon_full <= {2'b00, cfg.lon_window});
		sel_in = SEL_FIX;
		nb_in = 1'b0;
		unique case (feature_category)
			CAT_AIRPORT: sel_in = SEL_AIRPORT;
			CAT_VOR: sel_in = SEL_NAVAID;
			CAT_NDB: begin
				sel_in = SEL_NAVAID;
				nb_in = 1'b1;
			end
			CAT_FIX: sel_in = SEL_FIX;
			CAT_WAYPOINT: begin
				sel_in = SEL_FIX;
				nb_in = 1'b1;
			end
			default: sel_in = SEL_FIX;
		endcase
		op_in = OP_LOAD;
		keep = 1'b0;
		unique case (req_t'(req_type))
			REQ_LOAD: begin
				op_in = OP_LOAD;
				keep = (feature_category <= CAT_WAYPOINT) && in_box;
			end
			REQ_FETCH: begin
				op_in = OP_FETCH;
				keep = 1'b1;
			end
			REQ_CLEAR: begin
				op_in = OP_CLEAR;
				keep = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign east = prod_s2[39:15];
	assign sum = {1'b0, esq_s3} + {7'b0, nsq_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && keep;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= op_in;
			sel_s1 <= sel_in;
			ent_s1 <= {nb_in, feature_id};
			north_s1 <= north_full[LATWIN_W-1:0];
			adlon_s1 <= adlon_full[LONWIN_W-1:0];
			op_s2 <= op_s1;
			sel_s2 <= sel_s1;
			ent_s2 <= ent_s1;
			north_s2 <= north_s1;
			prod_s2 <= adlon_s1 * cfg.lon_scale;
			op_s3 <= op_s2;
			sel_s3 <= sel_s2;
			ent_s3 <= ent_s2;
			nsq_s3 <= north_s2 * north_s2;
			esq_s3 <= east * east;
			item_s4.op <= op_s3;
			item_s4.sel <= sel_s3;
			item_s4.entry <= ent_s3;
			item_s4.range_sq <= (|sum[50:48]) ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
		end
	end

	assign push = v_s4 && !q_full;
	assign push_item = item_s4;

endmodule
`default_nettype wire

### sv/nfks_fifo.sv
// short request queue between front and back
// depends on nfks_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module nfks_fifo import nfks_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire q_item_t push_item,
	output logic         full,
	input  wire logic    pop,
	output q_item_t      pop_item,
	output logic         not_empty
);

	q_item_t slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_AW:0] cnt_q;

	assign full = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_item = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wptr_q] <= push_item;
	end

	`NFKS_NEVER(a_fifo_over, clk, arst_n, push && full, "push into full queue")
	`NFKS_NEVER(a_fifo_under, clk, arst_n, pop && !not_empty, "pop from empty queue")

endmodule
`default_nettype wire

### sv/nfks_sstore.sv
// distance sorted store: memory plus a shifting insert sequencer
// depends on nfks_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module nfks_sstore import nfks_pkg::*; #(
	parameter int DEPTH = AIRPORT_CAP_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               clear,
	input  wire logic               ins_start,
	input  wire logic [DIST_W-1:0]  ins_dist,
	input  wire logic [ENTRY_W-1:0] ins_entry,
	input  wire logic               rd_en,
	input  wire logic [AW-1:0]      rd_addr,
	output logic [ENTRY_W-1:0]      rd_entry,
	output logic [CW-1:0]           count,
	output logic                    busy
);

	localparam int MW = DIST_W + ENTRY_W;

	logic [MW-1:0] mem [DEPTH];
	logic [MW-1:0] rdata_q, wdata;
	logic [DIST_W-1:0] rdist;
	ins_state_t st_q, st_d;
	logic [CW-1:0] idx_q, idx_d, idm1, count_q;
	logic [DIST_W-1:0] d_q;
	logic [ENTRY_W-1:0] e_q;
	logic ren, we;
	logic [AW-1:0] raddr, waddr;

	assign rdist = rdata_q[MW-1:ENTRY_W];
	assign rd_entry = rdata_q[ENTRY_W-1:0];
	assign idm1 = idx_q - 1'b1;
	assign count = count_q;
	assign busy = (st_q != INS_IDLE);

	always_comb begin
		st_d = st_q;
		idx_d = idx_q;
		ren = 1'b0;
		raddr = rd_addr;
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = {d_q, e_q};
		unique case (st_q)
			INS_IDLE: begin
				ren = rd_en;
				if (ins_start) begin
					if (count_q < CW'(DEPTH)) begin
						idx_d = count_q;
						st_d = INS_SHIFT;
					end else begin
						// full: look at the farthest entry first
						ren = 1'b1;
						raddr = AW'(DEPTH - 1);
						st_d = INS_TOP;
					end
				end
			end
			INS_TOP: begin
				if (rdist > d_q) begin
					idx_d = CW'(DEPTH - 1);
					st_d = INS_SHIFT;
				end else begin
					st_d = INS_IDLE;
				end
			end
			INS_SHIFT: begin
				if (idx_q == '0) begin
					we = 1'b1;
					st_d = INS_IDLE;
				end else begin
					ren = 1'b1;
					raddr = idm1[AW-1:0];
					st_d = INS_CMP;
				end
			end
			INS_CMP: begin
				we = 1'b1;
				if (rdist > d_q) begin
					// move the farther neighbor up one place
					wdata = rdata_q;
					idx_d = idm1;
					st_d = INS_SHIFT;
				end else begin
					st_d = INS_IDLE;
				end
			end
			default: st_d = INS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= INS_IDLE;
			count_q <= '0;
		end else begin
			st_q <= st_d;
			if (clear) begin
				count_q <= '0;
			end else if (ins_start && st_q == INS_IDLE && count_q < CW'(DEPTH)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (ins_start && st_q == INS_IDLE) begin
			d_q <= ins_dist;
			e_q <= ins_entry;
		end
		if (we) mem[waddr] <= wdata;
		if (ren) rdata_q <= mem[raddr];
	end

	`NFKS_ASSERT(a_st_count, clk, arst_n, count_q <= CW'(DEPTH), "store count past depth")
	`NFKS_NEVER(a_st_rdbusy, clk, arst_n, rd_en && busy, "fetch read during insert")

endmodule
`default_nettype wire

### sv/nfks_back.sv
// back end: three sorted stores, fetch sequencing and result register
// depends on nfks_pkg, nfks_sstore and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module nfks_back import nfks_pkg::*; #(
	parameter int AIRPORT_CAP = AIRPORT_CAP_DEF,
	parameter int NAVAID_CAP  = NAVAID_CAP_DEF,
	parameter int FIX_DEPTH   = FIX_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [MAXC_W-1:0] max_count,
	input  wire logic              q_valid,
	input  wire q_item_t           q_item,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   valid_res,
	output logic [ID_W-1:0]        result_id,
	output logic [CAT_W-1:0]       result_category,
	output logic                   last
);

	localparam int A_AW = (AIRPORT_CAP > 1) ? $clog2(AIRPORT_CAP) : 1;
	localparam int N_AW = (NAVAID_CAP > 1) ? $clog2(NAVAID_CAP) : 1;
	localparam int F_AW = (FIX_DEPTH > 1) ? $clog2(FIX_DEPTH) : 1;
	localparam int A_CW = $clog2(AIRPORT_CAP + 1);
	localparam int N_CW = $clog2(NAVAID_CAP + 1);
	localparam int F_CW = $clog2(FIX_DEPTH + 1);
	localparam int SW0 = $clog2(AIRPORT_CAP + NAVAID_CAP + FIX_DEPTH + 1);
	localparam int SW = (SW0 > MAXC_W) ? SW0 : MAXC_W;

	bk_state_t st_q, st_d;
	logic clear;
	logic [2:0] start, rd, busy;
	logic [ENTRY_W-1:0] ent_a, ent_n, ent_f, ent;
	logic [A_CW-1:0] cnt_a;
	logic [N_CW-1:0] cnt_n;
	logic [F_CW-1:0] cnt_f;
	logic [SW-1:0] sum, total, p, q, r;
	logic in_range, is_last;
	sel_t fsel;
	logic emit_empty, emit_data;
	sel_t fsel_q;
	logic last_q;
	logic [RPOS_W-1:0] rp_q;
	logic out_valid_q;

	nfks_sstore #(.DEPTH(AIRPORT_CAP)) u_airport (
		.clk(clk), .arst_n(arst_n), .clear(clear),
		.ins_start(start[SEL_AIRPORT]), .ins_dist(q_item.range_sq),
		.ins_entry(q_item.entry),
		.rd_en(rd[SEL_AIRPORT]), .rd_addr(p[A_AW-1:0]), .rd_entry(ent_a),
		.count(cnt_a), .busy(busy[SEL_AIRPORT])
	);

	nfks_sstore #(.DEPTH(NAVAID_CAP)) u_navaid (
		.clk(clk), .arst_n(arst_n), .clear(clear),
		.ins_start(start[SEL_NAVAID]), .ins_dist(q_item.range_sq),
		.ins_entry(q_item.entry),
		.rd_en(rd[SEL_NAVAID]), .rd_addr(q[N_AW-1:0]), .rd_entry(ent_n),
		.count(cnt_n), .busy(busy[SEL_NAVAID])
	);

	nfks_sstore #(.DEPTH(FIX_DEPTH)) u_fix (
		.clk(clk), .arst_n(arst_n), .clear(clear),
		.ins_start(start[SEL_FIX]), .ins_dist(q_item.range_sq),
		.ins_entry(q_item.entry),
		.rd_en(rd[SEL_FIX]), .rd_addr(r[F_AW-1:0]), .rd_entry(ent_f),
		.count(cnt_f), .busy(busy[SEL_FIX])
	);

	// query length and position split over the three stores
	always_comb begin
		sum = SW'(cnt_a) + SW'(cnt_n) + SW'(cnt_f);
		total = (sum > SW'(max_count)) ? SW'(max_count) : sum;
		p = SW'(rp_q);
		q = p - SW'(cnt_a);
		r = q - SW'(cnt_n);
		in_range = (p < total);
		is_last = ((p + 1'b1) == total);
		if (p < SW'(cnt_a)) begin
			fsel = SEL_AIRPORT;
		end else if (q < SW'(cnt_n)) begin
			fsel = SEL_NAVAID;
		end else begin
			fsel = SEL_FIX;
		end
	end

	always_comb begin
		st_d = st_q;
		pop = 1'b0;
		clear = 1'b0;
		start = '0;
		rd = '0;
		emit_empty = 1'b0;
		emit_data = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				if (q_valid) begin
					unique case (q_item.op)
						OP_CLEAR: begin
							pop = 1'b1;
							clear = 1'b1;
						end
						OP_LOAD: begin
							pop = 1'b1;
							start[q_item.sel] = 1'b1;
							st_d = BK_LOAD;
						end
						OP_FETCH: begin
							if (!out_valid_q) begin
								pop = 1'b1;
								if (in_range) begin
									rd[fsel] = 1'b1;
									st_d = BK_FETCH;
								end else begin
									emit_empty = 1'b1;
								end
							end
						end
						default: pop = 1'b1;
					endcase
				end
			end
			BK_LOAD: begin
				if (busy == '0) st_d = BK_IDLE;
			end
			BK_FETCH: begin
				emit_data = 1'b1;
				st_d = BK_IDLE;
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		unique case (fsel_q)
			SEL_AIRPORT: ent = ent_a;
			SEL_NAVAID: ent = ent_n;
			default: ent = ent_f;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			rp_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (clear) begin
				rp_q <= '0;
			end else if (pop && q_item.op == OP_FETCH && in_range) begin
				rp_q <= rp_q + 1'b1;
			end
			if (emit_empty || emit_data) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			fsel_q <= fsel;
			last_q <= is_last;
		end
		if (emit_empty) begin
			valid_res <= 1'b0;
			result_id <= '0;
			result_category <= '0;
			last <= 1'b0;
		end else if (emit_data) begin
			valid_res <= 1'b1;
			result_id <= ent[ID_W-1:0];
			last <= last_q;
			unique case (fsel_q)
				SEL_AIRPORT: result_category <= CAT_AIRPORT;
				SEL_NAVAID: result_category <= ent[ID_W] ? CAT_NDB : CAT_VOR;
				default: result_category <= ent[ID_W] ? CAT_WAYPOINT : CAT_FIX;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	`NFKS_NEVER(a_bk_pop, clk, arst_n, pop && st_q != BK_IDLE, "queue popped while busy")
	`NFKS_NEVER(a_bk_emit, clk, arst_n, (emit_empty || emit_data) && out_valid_q,
		"result overwritten before taken")

endmodule
`default_nettype wire

### sv/nearest_feature_top_k_select.sv
// nearest feature selector: every kept request passes the distance pipeline, then the queue
// a load holds the store sequencer while it shifts each farther entry up one place; into a full
// store it first compares with the farthest entry and may drop out
// a fetch result is registered after the store read in the fetch state, or straight from idle when past the end,
// one fetch in flight at a time; the sequencer on the single store memory port sets the load rate
// arst_n clears counts, read position and config (lon_scale to 32768); store contents undefined
`default_nettype none
module nearest_feature_top_k_select import nfks_pkg::*; #(
	parameter int AIRPORT_CAP = AIRPORT_CAP_DEF,
	parameter int NAVAID_CAP  = NAVAID_CAP_DEF,
	parameter int FIX_DEPTH   = FIX_DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration write port
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	// request channel
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [1:0]              req_type,
	input  wire logic [ID_W-1:0]         feature_id,
	input  wire logic [CAT_W-1:0]        feature_category,
	input  wire logic signed [LAT_W-1:0] feature_lat,
	input  wire logic signed [LON_W-1:0] feature_lon,
	// result channel
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic                         valid_res,
	output logic [ID_W-1:0]              result_id,
	output logic [CAT_W-1:0]             result_category,
	output logic                         last
);

	// configuration registers; the user must write them only while idle, the block does not enforce it
	geo_cfg_t geo_q;
	logic [MAXC_W-1:0] max_count_q;

	// front to back queue
	logic push, q_full, pop, q_valid;
	q_item_t push_item, q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geo_q.own_lat <= '0;
			geo_q.own_lon <= '0;
			geo_q.lat_window <= '0;
			geo_q.lon_window <= '0;
			geo_q.lon_scale <= LON_SCALE_RST;
			max_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_OWN_LAT: geo_q.own_lat <= cfg_data[LAT_W-1:0];
				CFG_OWN_LON: geo_q.own_lon <= cfg_data[LON_W-1:0];
				CFG_LAT_WINDOW: geo_q.lat_window <= cfg_data[LATWIN_W-1:0];
				CFG_LON_WINDOW: geo_q.lon_window <= cfg_data[LONWIN_W-1:0];
				CFG_LON_SCALE: geo_q.lon_scale <= cfg_data[SCALE_W-1:0];
				CFG_MAX_COUNT: max_count_q <= cfg_data[MAXC_W-1:0];
				default: ;
			endcase
		end
	end

	// front: box test and squared distance, drops features that are not kept
	nfks_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(geo_q),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .feature_id(feature_id),
		.feature_category(feature_category),
		.feature_lat(feature_lat), .feature_lon(feature_lon),
		.push(push), .push_item(push_item), .q_full(q_full)
	);

	// queue decouples the distance pipeline from the store sequencer
	nfks_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_item(push_item), .full(q_full),
		.pop(pop), .pop_item(q_item), .not_empty(q_valid)
	);

	// back: sorted inserts, clears and fetch readout in request order
	nfks_back #(
		.AIRPORT_CAP(AIRPORT_CAP),
		.NAVAID_CAP(NAVAID_CAP),
		.FIX_DEPTH(FIX_DEPTH)
	) u_back (
		.clk(clk), .arst_n(arst_n), .max_count(max_count_q),
		.q_valid(q_valid), .q_item(q_item), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.valid_res(valid_res), .result_id(result_id),
		.result_category(result_category), .last(last)
	);

endmodule
`default_nettype wire
